// ===== sv/mlls_pkg.sv =====
package mlls_pkg;

	localparam int unsigned SLOTS_PER_ITEM = 32;
	localparam int unsigned SLOT_CNT_W     = $clog2(SLOTS_PER_ITEM);
	localparam int unsigned HEADER_SLOTS   = 3;
	localparam int unsigned TOP_DATA_BIT   = 28;
	localparam int unsigned WORD_W         = TOP_DATA_BIT + 1;
	localparam int unsigned MAX_LANES      = 4;
	localparam int unsigned DEF_LANES      = 4;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LED   = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	typedef logic [WORD_W-1:0]         word_t;
	typedef logic [SLOTS_PER_ITEM-1:0] pattern_t;

	typedef struct packed {
		logic [MAX_LANES-1:0] lane_bits;
		logic                 last;
	} slot_t;

	// Full 32-slot pattern of one lane, first slot in the top bit.
	function automatic pattern_t lane_pattern(input logic [1:0] cmd, input word_t word);
		pattern_t pat;
		case (cmd)
			CMD_START: pat = '0;
			CMD_LED:   pat = {{HEADER_SLOTS{1'b1}}, word};
			default:   pat = '1;
		endcase
		return pat;
	endfunction

endpackage

// ===== sv/multilane_led_frame_serializer_top.sv =====
// channel | handshake           | payload
// in      | in_valid / in_ready | command, lane0_word .. lane3_word
// out     | out_valid/out_ready | lane_bits, last_slot
//
// Each transaction on in other than a reserved command expands to 32 slots, one per
// cycle while out is not stalled; the slot counter in the shifter counts them.
// The next item is taken in the cycle the 32nd slot moves to the output register.
// A reserved command is taken and gives no slots.
// Reset clears the busy flag, the slot counter and out_valid.
// A stall on out holds the output register and freezes the shifter.
module multilane_led_frame_serializer_top #(
	parameter int unsigned LANES = mlls_pkg::DEF_LANES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  mlls_pkg::word_t         lane0_word,
	input  mlls_pkg::word_t         lane1_word,
	input  mlls_pkg::word_t         lane2_word,
	input  mlls_pkg::word_t         lane3_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [mlls_pkg::MAX_LANES-1:0] lane_bits,
	output logic                    last_slot
);
	import mlls_pkg::*;

	word_t  words [MAX_LANES];
	slot_t  slot;
	slot_t  slot_q;
	logic   busy;
	logic   advance;
	logic   load;
	logic   out_valid_q;

	assign words[0] = lane0_word;
	assign words[1] = lane1_word;
	assign words[2] = lane2_word;
	assign words[3] = lane3_word;

	assign advance  = busy && (!out_valid_q || out_ready);
	assign in_ready = !busy || (slot.last && advance);
	assign load     = in_valid && in_ready;

	mlls_slot_gen #(
		.LANES (LANES)
	) u_slot_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.cmd     (command),
		.words   (words),
		.advance (advance),
		.busy    (busy),
		.slot    (slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q <= slot;
		end
	end

	assign out_valid = out_valid_q;
	assign lane_bits = slot_q.lane_bits;
	assign last_slot = slot_q.last;

endmodule

// ===== sv/mlls_slot_gen.sv =====
module mlls_slot_gen #(
	parameter int unsigned LANES = mlls_pkg::DEF_LANES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [1:0]          cmd,
	input  mlls_pkg::word_t     words [mlls_pkg::MAX_LANES],
	input  logic                advance,
	output logic                busy,
	output mlls_pkg::slot_t     slot
);
	import mlls_pkg::*;

	pattern_t               shift_q [LANES];
	logic [SLOT_CNT_W-1:0]  cnt_q;
	logic                   busy_q;
	logic                   at_last;

	assign at_last = (cnt_q == SLOT_CNT_W'(SLOTS_PER_ITEM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			// reserved command is taken and dropped
			busy_q <= (cmd != CMD_RSVD);
			cnt_q  <= '0;
		end else if (advance) begin
			cnt_q <= cnt_q + 1'b1;
			if (at_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (load) begin
				shift_q[l] <= lane_pattern(cmd, words[l]);
			end else if (advance) begin
				shift_q[l] <= {shift_q[l][SLOTS_PER_ITEM-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		slot.lane_bits = '0;
		for (int l = 0; l < LANES; l++) begin
			slot.lane_bits[l] = shift_q[l][SLOTS_PER_ITEM-1];
		end
		slot.last = at_last;
	end

	assign busy = busy_q;

endmodule

// ===== sv/mlls_checker.sv =====
module mlls_checker #(
	parameter int unsigned LANES = mlls_pkg::DEF_LANES
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [1:0]              command,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [mlls_pkg::MAX_LANES-1:0] lane_bits,
	input logic                    last_slot
);
	import mlls_pkg::*;

	logic [MAX_LANES-1:0] unused_mask;
	assign unused_mask = ~((MAX_LANES)'((1 << LANES) - 1));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lane_bits) && $stable(last_slot))
		else $error("output changed while stalled");

	a_unused_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lane_bits & unused_mask) == '0)
		else $error("unused lane driven");

	a_slots_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_slot |=> out_valid)
		else $error("gap inside a slot run");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command != CMD_RSVD |=> !in_ready)
		else $error("input ready right after taking a frame command");

endmodule

bind multilane_led_frame_serializer_top mlls_checker #(.LANES(LANES)) u_mlls_checker (.*);

// ===== sim/tb_multilane_led_frame_serializer_top.sv =====
module tb_multilane_led_frame_serializer_top #(
	parameter int unsigned LANES = mlls_pkg::DEF_LANES
);
	timeunit 1ns;
	timeprecision 1ps;

	import mlls_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned USED_LANES   = (LANES > MAX_LANES) ? MAX_LANES : LANES;
	localparam logic [MAX_LANES-1:0] LANE_MASK = MAX_LANES'((1 << USED_LANES) - 1);
	localparam word_t WORD_ONES = '1;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_e;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [1:0]           command    = CMD_START;
	word_t                lane0_word = '0;
	word_t                lane1_word = '0;
	word_t                lane2_word = '0;
	word_t                lane3_word = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [MAX_LANES-1:0] lane_bits;
	logic                 last_slot;

	slot_t       slots_due[$];
	int unsigned mismatches    = 0;
	int unsigned slots_checked = 0;
	int unsigned cycles        = 0;
	int unsigned cmd_count[4]  = '{0, 0, 0, 0};
	int unsigned burst_left    = 1;

	rx_mode_e    rx_mode    = RX_FREE;
	int unsigned rx_left    = 0;
	logic [1:0]  rx_phase   = '0;

	multilane_led_frame_serializer_top #(
		.LANES(LANES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.lane0_word(lane0_word),
		.lane1_word(lane1_word),
		.lane2_word(lane2_word),
		.lane3_word(lane3_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.lane_bits (lane_bits),
		.last_slot (last_slot)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d slots still due", cycles, slots_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Expand one command into the 32 slots it must produce; a reserved command produces none.
	function automatic void queue_frame_slots(input logic [1:0] cmd,
		input word_t words [MAX_LANES]);
		slot_t       s;
		int unsigned pos;
		if (cmd == CMD_RSVD)
			return;
		for (int unsigned slot = 0; slot < SLOTS_PER_ITEM; slot++) begin
			s.lane_bits = '0;
			case (cmd)
				CMD_START: s.lane_bits = '0;
				CMD_END:   s.lane_bits = '1;
				default: begin
					if (slot < HEADER_SLOTS) begin
						s.lane_bits = '1;
					end else begin
						pos = TOP_DATA_BIT - (slot - HEADER_SLOTS);
						for (int unsigned lane = 0; lane < MAX_LANES; lane++)
							s.lane_bits[lane] = words[lane][pos];
					end
				end
			endcase
			s.lane_bits &= LANE_MASK;
			s.last = (slot == SLOTS_PER_ITEM - 1);
			slots_due.push_back(s);
		end
	endfunction

	// Check the outgoing transaction first: a slot can never belong to an item
	// taken at the same edge.
	always @(posedge clk) begin
		slot_t expected;
		word_t words [MAX_LANES];
		if (out_valid && out_ready) begin
			slots_checked++;
			if (slots_due.size() == 0) begin
				$error("unexpected slot: lane_bits %h last_slot %b", lane_bits, last_slot);
				mismatches++;
			end else begin
				expected = slots_due.pop_front();
				if (lane_bits !== expected.lane_bits) begin
					$error("lane_bits: expected %h, got %h", expected.lane_bits, lane_bits);
					mismatches++;
				end
				if (last_slot !== expected.last) begin
					$error("last_slot: expected %b, got %b", expected.last, last_slot);
					mismatches++;
				end
			end
		end
		if (in_valid && in_ready) begin
			words = '{lane0_word, lane1_word, lane2_word, lane3_word};
			cmd_count[command]++;
			queue_frame_slots(command, words);
		end
	end

	// Receiver backpressure: switch between free flow, coin flips, a fixed
	// 3-of-4 pattern and long starvation.
	always @(posedge clk) begin
		rx_phase <= rx_phase + 2'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			rx_left <= $urandom_range(32, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_ready <= (rx_phase != 2'd0);
			default:     out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	function automatic word_t rand_word();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return WORD_ONES;
		return word_t'($urandom);
	endfunction

	// Present one item, hold it until taken, then maybe end the burst.
	task automatic send_item(input logic [1:0] cmd, input word_t w0, input word_t w1,
		input word_t w2, input word_t w3);
		int unsigned gap;
		in_valid   <= 1'b1;
		command    <= cmd;
		lane0_word <= w0;
		lane1_word <= w1;
		lane2_word <= w2;
		lane3_word <= w3;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 40);
			in_valid <= 1'b0;
			// scramble the idle command and lane0 word; they must be ignored
			command    <= 2'($urandom);
			lane0_word <= rand_word();
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) :
				$urandom_range(1, 5);
		end
	endtask

	task automatic send_led_random();
		send_item(CMD_LED, rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	task automatic test_frame_extremes();
		send_item(CMD_START, '0, '0, '0, '0);
		send_item(CMD_LED, '0, '0, '0, '0);
		send_item(CMD_LED, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
		send_item(CMD_LED, 29'h15555555, 29'h0AAAAAAA, 29'h15555555, 29'h0AAAAAAA);
		send_item(CMD_LED, 29'h0AAAAAAA, 29'h15555555, 29'h0AAAAAAA, 29'h15555555);
		// brightness field only, then color field only
		send_item(CMD_LED, 29'h1F000000, 29'h1F000000, 29'h1F000000, 29'h1F000000);
		send_item(CMD_LED, 29'h00FFFFFF, 29'h00FFFFFF, 29'h00FFFFFF, 29'h00FFFFFF);
		send_item(CMD_LED, 29'h10000000, 29'h00000001, '0, WORD_ONES);
		send_item(CMD_END, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
		// empty frame
		send_item(CMD_START, WORD_ONES, '0, WORD_ONES, '0);
		send_item(CMD_END, '0, '0, '0, '0);
	endtask

	task automatic test_reserved_command();
		send_item(CMD_RSVD, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
		send_item(CMD_RSVD, '0, '0, '0, '0);
		send_item(CMD_START, '0, '0, '0, '0);
		send_item(CMD_RSVD, 29'h15555555, 29'h0AAAAAAA, '0, WORD_ONES);
		send_led_random();
		send_item(CMD_RSVD, rand_word(), rand_word(), rand_word(), rand_word());
		send_item(CMD_END, '0, '0, '0, '0);
	endtask

	task automatic test_random_frames();
		int unsigned sent;
		int unsigned pick;
		int unsigned leds;
		logic [1:0]  cmd;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				leds = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				send_item(CMD_START, rand_word(), rand_word(), rand_word(), rand_word());
				repeat (leds) send_led_random();
				send_item(CMD_END, rand_word(), rand_word(), rand_word(), rand_word());
				sent += leds + 2;
			end else if (pick < 90) begin
				// broken frame: missing end, or missing both start and end
				leds = $urandom_range(1, 4);
				if (pick < 85) begin
					send_item(CMD_START, rand_word(), rand_word(), rand_word(), rand_word());
					sent++;
				end
				repeat (leds) send_led_random();
				sent += leds;
			end else begin
				cmd = 2'($urandom_range(0, 3));
				send_item(cmd, rand_word(), rand_word(), rand_word(), rand_word());
				if (cmd != CMD_RSVD)
					sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_extremes();
		test_reserved_command();
		test_random_frames();

		in_valid <= 1'b0;
		while (slots_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d start, %0d LED, %0d end and %0d reserved commands on %0d lanes",
			cmd_count[CMD_START], cmd_count[CMD_LED], cmd_count[CMD_END],
			cmd_count[CMD_RSVD], USED_LANES);
		$display("Checked %0d slots in %0d cycles, %0d mismatches",
			slots_checked, cycles, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
